FILE: rtl/core/i2da_pkg.sv
// Shared constants and types for the 64-bit binary to decimal ASCII converter.
`timescale 1ns / 1ps

package i2da_pkg;

    localparam int VALUE_W        = 64;
    localparam int LEN_W          = 5;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int S_TDATA_W      = 72;   // value + max_len, padded to bytes

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

    typedef struct packed {
        logic             load;
        logic             negative;
        logic [LEN_W-1:0] limit;
    } emit_cmd_t;

endpackage

FILE: rtl/core/int64_to_decimal_ascii.sv
// Top level: 64-bit binary to decimal ASCII text converter with stream ports.
// Usage:
//   Input beat (s_*): s_tdata carries value and max_len, s_tuser the signed
//   selector. One beat per conversion.
//   Output beats (m_*): one ASCII character per beat, most significant digit
//   first, '-' ahead of a negative signed value; m_tlast marks the final one.
//   A max_len of 0 gives no beats; 21 or more never truncates.
// Timing:
//   The double-dabble shifts one bit per cycle, then hands the digits over. The
//   emitter then spends one cycle per digit slot while the output is not stalled
//   (leading zeros are dropped without a beat) and one for a '-'.
//   s_tready is high only while both the converter and the emitter are idle;
//   the final beat may still sit in the output register when the next item
//   is taken.
// Reset: aresetn (synchronous, active low) drops all work and any pending beat.
// Stall: with m_tready low a pending output beat holds and the digit walk pauses.
`timescale 1ns / 1ps

module int64_to_decimal_ascii #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2da_pkg::S_TDATA_W-1:0]    s_tdata,   // [63:0] value, [68:64] max_len
    input  logic                              s_tuser,   // [0] func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2da_pkg::CHAR_W-1:0]       m_tdata,   // [7:0] text_char
    output logic                              m_tlast    // last
);
    import i2da_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;

    logic               s_beat;
    logic [VALUE_W-1:0] in_value;
    logic [LEN_W-1:0]   in_limit;
    logic               in_neg;
    logic               dab_start;
    logic [VALUE_W-1:0] magnitude;
    dab_status_t        dab_st;
    logic [BCD_W-1:0]   bcd;
    emit_cmd_t          emit_cmd;
    logic               emit_busy;
    logic               neg_reg;
    logic [LEN_W-1:0]   limit_reg;

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_limit  = s_tdata[VALUE_W +: LEN_W];
    assign in_neg    = s_tuser && in_value[VALUE_W-1];
    assign s_tready  = !dab_st.busy && !emit_busy;
    assign s_beat    = s_tvalid && s_tready;
    assign dab_start = s_beat && in_limit != '0;
    assign magnitude = in_neg ? (~in_value + 1'b1) : in_value;

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            neg_reg   <= in_neg;
            limit_reg <= in_limit;
        end
    end

    assign emit_cmd.load     = dab_st.done;
    assign emit_cmd.negative = neg_reg;
    assign emit_cmd.limit    = limit_reg;

    i2da_dabble #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dabble (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dab_start),
        .magnitude(magnitude),
        .status   (dab_st),
        .bcd      (bcd)
    );

    i2da_emit #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (emit_cmd),
        .bcd     (bcd),
        .busy    (emit_busy),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

`ifndef ASSERT_OFF
    // digits handed over always start the emitter
    a_load_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_st.done |=> emit_busy)
        else $error("emitter did not start after conversion");

    // converter and emitter never work at once
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dab_st.busy && !dab_st.done && emit_busy))
        else $error("conversion overlaps emission");

    // a nonzero limit launches a conversion
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[VALUE_W +: LEN_W] != '0) |=> dab_st.busy)
        else $error("accepted beat did not start conversion");
`endif

endmodule

FILE: rtl/core/i2da_dabble.sv
// Bit-serial double-dabble: shifts the magnitude in one bit per cycle into BCD digits.
`timescale 1ns / 1ps

module i2da_dabble #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        start,
    input  logic [i2da_pkg::VALUE_W-1:0]                magnitude,
    output i2da_pkg::dab_status_t                       status,
    output logic [MAX_DIGITS*i2da_pkg::DIGIT_W-1:0]     bcd
);
    import i2da_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = magnitude;
            bcd_next   = '0;
            cnt_next   = '0;
            run_next   = 1'b1;
        end else if (run_reg) begin
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = run_reg | done_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule

FILE: rtl/core/i2da_emit.sv
// Character emitter: walks BCD digits from the top, one per cycle unless stalled, to the output.
`timescale 1ns / 1ps

module i2da_emit #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  i2da_pkg::emit_cmd_t                         cmd,
    input  logic [MAX_DIGITS*i2da_pkg::DIGIT_W-1:0]     bcd,
    output logic                                        busy,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [i2da_pkg::CHAR_W-1:0]                 m_tdata,   // [7:0] text_char
    output logic                                        m_tlast    // last
);
    import i2da_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int POS_W = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        EM_IDLE = 2'b01,
        EM_RUN  = 2'b10
    } em_state_t;

    em_state_t          state_reg, state_next;
    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               started_reg, started_next;
    logic               minus_reg, minus_next;
    logic [LEN_W-1:0]   limit_reg, limit_next;
    logic [LEN_W-1:0]   sent_reg, sent_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    logic               slot_free;
    logic [DIGIT_W-1:0] top_digit;
    logic               hit_limit;

    assign slot_free = !valid_reg || m_tready;
    assign top_digit = digits_reg[BCD_W-1 -: DIGIT_W];
    assign hit_limit = ({1'b0, sent_reg} + 1'b1) == {1'b0, limit_reg};

    always_comb begin
        state_next   = state_reg;
        digits_next  = digits_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        minus_next   = minus_reg;
        limit_next   = limit_reg;
        sent_next    = sent_reg;
        valid_next   = valid_reg && !m_tready;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            EM_IDLE: begin
                if (cmd.load) begin
                    state_next   = EM_RUN;
                    digits_next  = bcd;
                    pos_next     = POS_W'(MAX_DIGITS - 1);
                    started_next = 1'b0;
                    minus_next   = cmd.negative;
                    limit_next   = cmd.limit;
                    sent_next    = '0;
                end
            end
            EM_RUN: begin
                if (slot_free) begin
                    if (minus_reg) begin
                        minus_next = 1'b0;
                        valid_next = 1'b1;
                        char_next  = CHAR_MINUS;
                        last_next  = hit_limit;
                        sent_next  = sent_reg + 1'b1;
                        if (hit_limit) begin
                            state_next = EM_IDLE;
                        end
                    end else if (!started_reg && top_digit == '0 && pos_reg != '0) begin
                        // leading zero: drop it, no beat
                        digits_next = {digits_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        pos_next    = pos_reg - 1'b1;
                    end else begin
                        digits_next  = {digits_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        pos_next     = pos_reg - 1'b1;
                        started_next = 1'b1;
                        valid_next   = 1'b1;
                        char_next    = CHAR_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                        last_next    = hit_limit || pos_reg == '0;
                        sent_next    = sent_reg + 1'b1;
                        if (hit_limit || pos_reg == '0) begin
                            state_next = EM_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        digits_reg  <= digits_next;
        pos_reg     <= pos_next;
        started_reg <= started_next;
        minus_reg   <= minus_next;
        limit_reg   <= limit_next;
        sent_reg    <= sent_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign busy     = state_reg != EM_IDLE;
    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: dv/decimal_text_checker.sv
// Checker for the decimal ASCII converter: predicts the character beats and compares them.
`timescale 1ns / 1ps

module decimal_text_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [i2da_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [i2da_pkg::CHAR_W-1:0]    m_tdata,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             pending_chars
);
    import i2da_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } text_beat_t;

    text_beat_t expected_text[$];

    // Push the characters one conversion should produce, most significant first.
    task automatic predict_decimal_text(input logic is_signed, input logic [VALUE_W-1:0] value,
                                        input logic [LEN_W-1:0] max_len);
        logic [VALUE_W-1:0] magnitude;
        logic [DIGIT_W-1:0] digits[MAX_DIGITS_DEF];
        int                 ndig;
        int                 room;
        int                 emitted;
        logic               negative;
        text_beat_t         beat;
        negative = is_signed && value[VALUE_W-1];
        magnitude = negative ? (~value + 1'b1) : value;
        ndig = 0;
        emitted = 0;
        if (max_len != '0) begin
            if (magnitude == '0) begin
                digits[0] = '0;
                ndig = 1;
            end else begin
                while (magnitude != '0 && ndig < MAX_DIGITS_DEF) begin
                    digits[ndig] = DIGIT_W'(magnitude % 10);
                    magnitude = magnitude / 10;
                    ndig++;
                end
            end
            room = int'(max_len);
            if (negative) begin
                beat.text_char = CHAR_MINUS;
                beat.last = 1'b0;
                expected_text.push_back(beat);
                emitted = 1;
                room = room - 1;
            end
            if (room > ndig)
                room = ndig;
            for (int i = 0; i < room; i++) begin
                beat.text_char = CHAR_ZERO + CHAR_W'(digits[ndig - 1 - i]);
                beat.last = 1'b0;
                expected_text.push_back(beat);
                emitted++;
            end
            // final character of the conversion carries the marker
            if (emitted > 0)
                expected_text[expected_text.size() - 1].last = 1'b1;
        end
    endtask

    initial begin
        mismatch_count = 0;
        pending_chars = 0;
    end

    always @(posedge aclk) begin
        text_beat_t want;
        if (!aresetn) begin
            expected_text.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_decimal_text(s_tuser, s_tdata[VALUE_W-1:0],
                                     s_tdata[VALUE_W+LEN_W-1:VALUE_W]);
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual char %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (want.text_char !== m_tdata || want.last !== m_tlast) begin
                        $display("%0t: beat mismatch: expected char %h last %b, actual char %h last %b",
                                 $time, want.text_char, want.last, m_tdata, m_tlast);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        pending_chars <= expected_text.size();
    end

endmodule

FILE: dv/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the decimal ASCII converter.
`timescale 1ns / 1ps

module testbench;
    import i2da_pkg::*;

    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;
    localparam int   STALL_LIMIT   = 3000;
    localparam int   ITEMS_PER_PHASE = 35;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [CHAR_W-1:0]      m_tdata;
    logic                   m_tlast;

    int mismatch_count;
    int pending_chars;
    int send_idle_pct = 35;
    int recv_idle_pct = 58;
    int quiet_cycles = 0;

    int64_to_decimal_ascii u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_chars  (pending_chars)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: too long without any beat on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = {$urandom, $urandom} >> $urandom_range(63);
            2: v = VALUE_W'($urandom_range(999));
            3: v = pow10($urandom_range(19)) + VALUE_W'($urandom_range(2)) - 1;
            4: v = -VALUE_W'($urandom_range(99999));
            default: v = {$urandom, $urandom} | {1'b1, {VALUE_W-1{1'b0}}};
        endcase
        return v;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_item(input logic is_signed, input logic [VALUE_W-1:0] value,
                             input logic [LEN_W-1:0] max_len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_signed;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-LEN_W){1'b0}}, max_len, value};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars != 0)
            @(posedge aclk);
    endtask

    task automatic send_random();
        logic [LEN_W-1:0] max_len;
        max_len = ($urandom_range(1) == 0) ? LEN_W'($urandom_range(31))
                                            : LEN_W'($urandom_range(31, 19));
        send_item(logic'($urandom_range(1)), pick_value(), max_len);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corner cases
        send_item(FUNC_UNSIGNED, 64'd0, 5'd1);
        send_item(FUNC_UNSIGNED, 64'd0, 5'd0);
        send_item(FUNC_SIGNED, 64'd0, 5'd31);
        send_item(FUNC_UNSIGNED, '1, 5'd31);
        send_item(FUNC_UNSIGNED, '1, 5'd20);
        send_item(FUNC_UNSIGNED, '1, 5'd21);
        send_item(FUNC_UNSIGNED, '1, 5'd19);
        send_item(FUNC_SIGNED, 64'h8000_0000_0000_0000, 5'd31);
        send_item(FUNC_SIGNED, 64'h8000_0000_0000_0000, 5'd20);
        send_item(FUNC_UNSIGNED, 64'h8000_0000_0000_0000, 5'd31);
        send_item(FUNC_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 5'd31);
        send_item(FUNC_SIGNED, '1, 5'd1);
        send_item(FUNC_SIGNED, '1, 5'd2);
        send_item(FUNC_SIGNED, '1, 5'd31);
        send_item(FUNC_UNSIGNED, '1, 5'd1);
        send_item(FUNC_UNSIGNED, 64'd12345, 5'd3);
        send_item(FUNC_SIGNED, -64'd12345, 5'd3);
        send_item(FUNC_SIGNED, -64'd12345, 5'd0);
        send_item(FUNC_UNSIGNED, 64'd1, 5'd1);
        send_item(FUNC_UNSIGNED, 64'd10, 5'd1);
        send_item(FUNC_UNSIGNED, pow10(19), 5'd20);
        send_item(FUNC_UNSIGNED, pow10(19) - 1, 5'd31);
        send_item(FUNC_UNSIGNED, 64'd99999, 5'd5);
        send_item(FUNC_SIGNED, 64'd42, 5'd16);

        // sender-side pause until the output side has caught up
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct <= 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct <= 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random();
                if ($urandom_range(14) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (120) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: int64_to_decimal_ascii.f
rtl/core/i2da_pkg.sv
rtl/core/i2da_dabble.sv
rtl/core/i2da_emit.sv
rtl/core/int64_to_decimal_ascii.sv
dv/decimal_text_checker.sv
dv/testbench.sv
